@@ rtl/keypad_two_key_text_entry_defines.svh @@
// Assertion macros for the keypad text entry RTL.
`ifndef KEYPAD_TWO_KEY_TEXT_ENTRY_DEFINES_SVH
`define KEYPAD_TWO_KEY_TEXT_ENTRY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KP2K_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad text entry check failed");

// Next-cycle implication, checked out of reset.
`define KP2K_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad text entry check failed");

`endif

@@ rtl/kp2k_pkg.sv @@
// Types, constants and lookup tables for the keypad text entry block.
`default_nettype none
package kp2k_pkg;

    localparam logic [3:0] MOVE_KEY   = 4'd12;
    localparam logic [3:0] SPACE_KEY  = 4'd5;
    localparam logic [3:0] KEY_UP     = 4'd2;
    localparam logic [3:0] KEY_LEFT   = 4'd4;
    localparam logic [3:0] KEY_RIGHT  = 4'd6;
    localparam logic [3:0] KEY_DOWN   = 4'd8;
    localparam logic [3:0] KEY_NEWLN  = 4'd9;
    localparam logic [3:0] DIGIT_ROW  = 4'd10;
    localparam logic [7:0] NO_CHAR    = 8'h2D;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [6:0] LINE2_ADDR = 7'h40;
    localparam logic [3:0] COL_LAST   = 4'hF;

    typedef struct packed {
        logic [6:0] cursor_addr;
        logic       first_pending;
        logic [3:0] first_key;
    } kp2k_state_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic       last;
    } kp2k_result_t;

    // Results caused by one press: count of 0, 1 or 2.
    typedef struct packed {
        logic [1:0]   count;
        kp2k_result_t res0;
        kp2k_result_t res1;
    } kp2k_step_t;

    // Keypad layout: column 0 is the right column.
    function automatic logic [3:0] key_of(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] k;
        k = 4'd0;
        case ({row, col})
            4'b00_00: k = 4'd3;
            4'b00_01: k = 4'd2;
            4'b00_10: k = 4'd1;
            4'b01_00: k = 4'd6;
            4'b01_01: k = 4'd5;
            4'b01_10: k = 4'd4;
            4'b10_00: k = 4'd9;
            4'b10_01: k = 4'd8;
            4'b10_10: k = 4'd7;
            4'b11_00: k = 4'd10;
            4'b11_01: k = 4'd11;
            4'b11_10: k = 4'd12;
            default:  k = 4'd0;
        endcase
        return k;
    endfunction

    // Character for a key pair; NO_CHAR where the pair means nothing.
    function automatic logic [7:0] char_of(input logic [3:0] a, input logic [3:0] b);
        logic [7:0] upper;
        logic [3:0] n;
        logic [7:0] ch;
        upper = 8'h00;
        n     = 4'd0;
        ch    = NO_CHAR;
        case (a)
            4'd2:    begin upper = 8'h41; n = 4'd3; end
            4'd3:    begin upper = 8'h44; n = 4'd3; end
            4'd4:    begin upper = 8'h47; n = 4'd3; end
            4'd5:    begin upper = 8'h4A; n = 4'd3; end
            4'd6:    begin upper = 8'h4D; n = 4'd3; end
            4'd7:    begin upper = 8'h50; n = 4'd4; end
            4'd8:    begin upper = 8'h54; n = 4'd3; end
            4'd9:    begin upper = 8'h57; n = 4'd4; end
            default: begin upper = 8'h00; n = 4'd0; end
        endcase
        if (a == DIGIT_ROW) begin
            case (b)
                4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9:
                    ch = 8'h30 + {4'd0, b};
                4'd10:   ch = 8'h23;
                4'd11:   ch = 8'h30;
                4'd12:   ch = 8'h2A;
                default: ch = NO_CHAR;
            endcase
        end else if (n != 4'd0 && b != 4'd0) begin
            if (b <= n) begin
                ch = upper + {4'd0, b} - 8'd1;
            end else if ({1'b0, b} <= {n, 1'b0}) begin
                ch = upper + 8'h20 + {4'd0, b} - {4'd0, n} - 8'd1;
            end
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

@@ rtl/kp2k_decode.sv @@
// Per-press decode: key lookup, pairing, cursor moves and result bytes.
`default_nettype none
module kp2k_decode (
    input  wire logic [1:0]          row,
    input  wire logic [2:0]          column_bits,
    input  wire kp2k_pkg::kp2k_state_t state_cur,
    output kp2k_pkg::kp2k_state_t    state_nxt,
    output kp2k_pkg::kp2k_step_t     step
);
    import kp2k_pkg::*;

    logic       col_ok;
    logic [1:0] col;
    logic [3:0] key;
    logic [6:0] c;
    logic [6:0] c_inc;
    logic       mv_ok;
    logic [6:0] mv_addr;
    logic       wr_ok;
    logic [7:0] ch;

    assign c     = state_cur.cursor_addr;
    assign c_inc = c + 7'd1;

    // Single-column patterns only
    always_comb
    begin
        col_ok = 1'b1;
        col    = 2'd0;
        case (column_bits)
            3'b001:  col = 2'd0;
            3'b010:  col = 2'd1;
            3'b100:  col = 2'd2;
            default: col_ok = 1'b0;
        endcase
    end

    assign key = key_of(row, col);

    // Cursor move for the second key after the move key
    always_comb
    begin
        mv_ok   = 1'b0;
        mv_addr = c;
        case (key)
            KEY_UP:
            begin
                mv_ok   = 1'b1;
                mv_addr = {3'b000, c[3:0]};
            end
            KEY_LEFT:
            begin
                mv_ok   = (c != 7'h00) && (c != LINE2_ADDR);
                mv_addr = c - 7'd1;
            end
            KEY_RIGHT:
            begin
                mv_ok   = (c[3:0] != COL_LAST);
                mv_addr = c_inc;
            end
            KEY_DOWN:
            begin
                mv_ok   = 1'b1;
                mv_addr = LINE2_ADDR | {3'b000, c[3:0]};
            end
            KEY_NEWLN:
            begin
                mv_ok   = 1'b1;
                mv_addr = LINE2_ADDR;
            end
            default:
            begin
                mv_ok   = 1'b0;
                mv_addr = c;
            end
        endcase
    end

    // Character for the pair
    assign ch    = (state_cur.first_key == MOVE_KEY) ? SPACE_CHAR
                                                     : char_of(state_cur.first_key, key);
    assign wr_ok = (state_cur.first_key == MOVE_KEY) ? (key == SPACE_KEY) : (ch != NO_CHAR);

    // Pairing and result assembly
    always_comb
    begin
        state_nxt = state_cur;
        step      = '0;
        if (col_ok) begin
            if (!state_cur.first_pending) begin
                state_nxt.first_pending = 1'b1;
                state_nxt.first_key     = key;
            end else begin
                state_nxt.first_pending = 1'b0;
                if (wr_ok) begin
                    step.res0.is_data  = 1'b1;
                    step.res0.lcd_byte = ch;
                    // Pull back when the write crosses into a new 16-column block
                    if (c_inc[3:0] == 4'd0 && c_inc != 7'h00 && c_inc != LINE2_ADDR) begin
                        step.count              = 2'd2;
                        step.res1.is_data       = 1'b0;
                        step.res1.lcd_byte      = {1'b1, c};
                        step.res1.last          = 1'b1;
                        state_nxt.cursor_addr   = c;
                    end else begin
                        step.count              = 2'd1;
                        step.res0.last          = 1'b1;
                        state_nxt.cursor_addr   = c_inc;
                    end
                end else if (state_cur.first_key == MOVE_KEY && mv_ok) begin
                    step.count            = 2'd1;
                    step.res0.is_data     = 1'b0;
                    step.res0.lcd_byte    = {1'b1, mv_addr};
                    step.res0.last        = 1'b1;
                    state_nxt.cursor_addr = mv_addr;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/keypad_two_key_text_entry.sv @@
// A request is registered in the input register, then decoded into the result register;
// the first result is valid once the result register is loaded, which waits while it is occupied.
// Throughput: one request per cycle while lcd_stall is low; a press with two results holds
// the result register for two output transfers, stalling requests meanwhile.
// Reset: cursor at address 0, no key pending, input and result registers empty.
`default_nettype none
`include "keypad_two_key_text_entry_defines.svh"
module keypad_two_key_text_entry (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       key_valid,
    output logic            key_stall,
    input  wire logic [1:0] row,
    input  wire logic [2:0] column_bits,
    output logic            lcd_valid,
    input  wire logic       lcd_stall,
    output logic            is_data,
    output logic [7:0]      lcd_byte,
    output logic            last
);
    import kp2k_pkg::*;

    logic         in_valid_reg;
    logic [1:0]   row_reg;
    logic [2:0]   column_bits_reg;
    kp2k_state_t  state_reg;
    kp2k_state_t  state_next;
    kp2k_step_t   step;
    logic [1:0]   cnt_reg;
    kp2k_result_t slot0_reg;
    kp2k_result_t slot1_reg;
    logic         out_fire;
    logic         adv;
    logic         key_fire;

    assign out_fire  = lcd_valid && !lcd_stall;
    // Result register frees up this cycle
    assign adv       = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_fire);
    assign key_stall = in_valid_reg && !adv;
    assign key_fire  = key_valid && !key_stall;

    assign lcd_valid = (cnt_reg != 2'd0);
    assign is_data   = slot0_reg.is_data;
    assign lcd_byte  = slot0_reg.lcd_byte;
    assign last      = slot0_reg.last;

    kp2k_decode u_decode (
        .row         (row_reg),
        .column_bits (column_bits_reg),
        .state_cur   (state_reg),
        .state_nxt   (state_next),
        .step        (step)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!key_stall) begin
            in_valid_reg <= key_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_fire) begin
            row_reg         <= row;
            column_bits_reg <= column_bits;
        end
    end

    // Pairing and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (in_valid_reg && adv) begin
            state_reg <= state_next;
        end
    end

    // Result register: two slots, slot0 drives the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else if (adv) begin
            cnt_reg <= in_valid_reg ? step.count : 2'd0;
        end else if (out_fire) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid_reg) begin
            slot0_reg <= step.res0;
            slot1_reg <= step.res1;
        end else if (out_fire && cnt_reg == 2'd2) begin
            slot0_reg <= slot1_reg;
        end
    end

    `KP2K_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg != 2'd3)
    `KP2K_ASSERT_NOW(a_cmd_bit7, lcd_valid && !is_data, lcd_byte[7])
    `KP2K_ASSERT_NOW(a_pair_order, cnt_reg == 2'd2,
                     slot0_reg.is_data && !slot0_reg.last && slot1_reg.last && !slot1_reg.is_data)
    `KP2K_ASSERT_NOW(a_single_last, cnt_reg == 2'd1, slot0_reg.last)
    `KP2K_ASSERT_NEXT(a_second_follows, out_fire && cnt_reg == 2'd2, lcd_valid && last)

endmodule
`default_nettype wire
